### rtl/core/reset_request_retry_handler_macros.svh
// ----------------------------------------------------------------------------
// reset request retry handler assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RESET_REQUEST_RETRY_HANDLER_MACROS_SVH
`define RESET_REQUEST_RETRY_HANDLER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RRRH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define RRRH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RRRH_ASSERT_NOW(label, clk, rst, ante, cons)
`define RRRH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/rrrh_pkg.sv
// ----------------------------------------------------------------------------
// rrrh_pkg
// shared types and codes of the reset request retry handler
// ----------------------------------------------------------------------------
package rrrh_pkg;

   localparam int CSR_WIDTH          = 16;
   localparam int TIMER_BITS_DEFAULT = 16;
   localparam logic [CSR_WIDTH-1:0] TICKS_RESET = 16'd1000;

   // event codes
   localparam logic [2:0] OP_DECOMP_FAIL = 3'd0;
   localparam logic [2:0] OP_RESET_REQ   = 3'd1;
   localparam logic [2:0] OP_RESET_ACK   = 3'd2;
   localparam logic [2:0] OP_TICK        = 3'd3;
   localparam logic [2:0] OP_LAYER_DOWN  = 3'd4;

   // send kinds
   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_RESET_REQ = 2'd1;
   localparam logic [1:0] KIND_RESET_ACK = 2'd2;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] packet_id;
      logic       link_opened;
   } req_type;

   typedef struct packed {
      logic [1:0] send_kind;
      logic [7:0] send_id;
      logic       ack_pending;
   } rsp_type;

endpackage

### rtl/core/rrrh_in_reg.sv
// ----------------------------------------------------------------------------
// rrrh_in_reg
// input register stage for incoming events
// ----------------------------------------------------------------------------
module rrrh_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rrrh_pkg::req_type in_req,
   input  logic             advance,
   output logic             valid,
   output rrrh_pkg::req_type req
);

   logic              valid_ff;
   logic              valid_in;
   rrrh_pkg::req_type req_ff;

   assign in_ready = !valid_ff || advance;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         req_ff <= in_req;
      end
   end

   assign valid = valid_ff;
   assign req   = req_ff;

endmodule

### rtl/core/rrrh_core.sv
// ----------------------------------------------------------------------------
// rrrh_core
// handshake state and per-event decision logic
// ----------------------------------------------------------------------------
`include "reset_request_retry_handler_macros.svh"

module rrrh_core #(
   parameter int TIMER_BITS = rrrh_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  rrrh_pkg::req_type              req,
   input  logic [rrrh_pkg::CSR_WIDTH-1:0] ticks_per_timeout,
   output rrrh_pkg::rsp_type              rsp
);

   localparam int CmpBits = (TIMER_BITS > rrrh_pkg::CSR_WIDTH) ?
                            TIMER_BITS : rrrh_pkg::CSR_WIDTH;
   localparam logic [CmpBits-1:0] TimerMax = CmpBits'({TIMER_BITS{1'b1}});

   logic                  pending_ff, pending_in;
   logic                  repeat_ff, repeat_in;
   logic [7:0]            id_ff, id_in;
   logic [7:0]            request_id_ff, request_id_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [TIMER_BITS-1:0] timer_load;
   logic [TIMER_BITS-1:0] timer_dec;
   logic [CmpBits-1:0]    ticks_ext;
   logic [7:0]            id_next;

   // zero counts as one tick, large values clamp to the timer range
   assign ticks_ext = CmpBits'(ticks_per_timeout);
   always_comb begin
      if (ticks_ext == '0) begin
         timer_load = TIMER_BITS'(1);
      end else if (ticks_ext > TimerMax) begin
         timer_load = {TIMER_BITS{1'b1}};
      end else begin
         timer_load = ticks_ext[TIMER_BITS-1:0];
      end
   end

   assign timer_dec = timer_ff - TIMER_BITS'(1);
   assign id_next   = id_ff + 8'd1;

   always_comb begin
      pending_in    = pending_ff;
      repeat_in     = repeat_ff;
      id_in         = id_ff;
      request_id_in = request_id_ff;
      timer_in      = timer_ff;
      rsp.send_kind = rrrh_pkg::KIND_NONE;
      rsp.send_id   = 8'd0;
      case (req.opcode)
         rrrh_pkg::OP_DECOMP_FAIL: begin
            if (req.link_opened) begin
               if (!pending_ff) begin
                  id_in         = id_next;
                  request_id_in = id_next;
                  rsp.send_kind = rrrh_pkg::KIND_RESET_REQ;
                  rsp.send_id   = id_next;
                  timer_in      = timer_load;
                  pending_in    = 1'b1;
               end else begin
                  repeat_in = 1'b1;
               end
            end
         end
         rrrh_pkg::OP_RESET_REQ: begin
            if (req.link_opened) begin
               rsp.send_kind = rrrh_pkg::KIND_RESET_ACK;
               rsp.send_id   = req.packet_id;
            end
         end
         rrrh_pkg::OP_RESET_ACK: begin
            if (pending_ff && (req.packet_id == request_id_ff)) begin
               pending_in = 1'b0;
               repeat_in  = 1'b0;
               timer_in   = '0;
            end
         end
         rrrh_pkg::OP_TICK: begin
            if (timer_ff != '0) begin
               timer_in = timer_dec;
               if (timer_dec == '0) begin
                  // expiry: resend only if another failure came in meanwhile
                  if (req.link_opened && repeat_ff) begin
                     rsp.send_kind = rrrh_pkg::KIND_RESET_REQ;
                     rsp.send_id   = request_id_ff;
                     timer_in      = timer_load;
                     repeat_in     = 1'b0;
                  end else begin
                     pending_in = 1'b0;
                     repeat_in  = 1'b0;
                  end
               end
            end
         end
         rrrh_pkg::OP_LAYER_DOWN: begin
            pending_in = 1'b0;
            repeat_in  = 1'b0;
            timer_in   = '0;
         end
         default: begin
         end
      endcase
      rsp.ack_pending = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 1'b0;
         repeat_ff     <= 1'b0;
         id_ff         <= 8'd0;
         request_id_ff <= 8'd0;
         timer_ff      <= '0;
      end else if (fire) begin
         pending_ff    <= pending_in;
         repeat_ff     <= repeat_in;
         id_ff         <= id_in;
         request_id_ff <= request_id_in;
         timer_ff      <= timer_in;
      end
   end

   `RRRH_ASSERT_NOW(a_repeat_needs_pending, clock, reset, repeat_ff, pending_ff)
   `RRRH_ASSERT_NOW(a_timer_needs_pending, clock, reset, timer_ff != '0, pending_ff)
   `RRRH_ASSERT_NEXT(a_request_arms, clock, reset, fire && (rsp.send_kind == rrrh_pkg::KIND_RESET_REQ), pending_ff && (timer_ff != '0))

endmodule

### rtl/core/rrrh_out_reg.sv
// ----------------------------------------------------------------------------
// rrrh_out_reg
// result register toward the response channel
// ----------------------------------------------------------------------------
module rrrh_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  rrrh_pkg::rsp_type rsp_in,
   output logic              out_valid,
   input  logic              out_ready,
   output rrrh_pkg::rsp_type rsp
);

   logic              valid_ff;
   logic              valid_in;
   rrrh_pkg::rsp_type rsp_ff;

   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/core/reset_request_retry_handler.sv
// ----------------------------------------------------------------------------
// reset_request_retry_handler
// path: a request taken into the input register passes through the core into the
// result register, which drives rsp_valid
// throughput: one request per cycle; while a result waits on rsp_ready one more
// request is held in the input register, then req_ready drops
// reset: flags, id counter, request id and timer clear; ticks_per_timeout is 1000
// ----------------------------------------------------------------------------
module reset_request_retry_handler #(
   parameter int TIMER_BITS = rrrh_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_opcode,
   input  logic [7:0]                     req_packet_id,
   input  logic                           req_link_opened,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_send_kind,
   output logic [7:0]                     rsp_send_id,
   output logic                           rsp_ack_pending,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrrh_pkg::CSR_WIDTH-1:0] csr_ticks_per_timeout
);

   logic [rrrh_pkg::CSR_WIDTH-1:0] ticks_ff;
   rrrh_pkg::req_type              in_req;
   rrrh_pkg::req_type              stage_req;
   rrrh_pkg::rsp_type              core_rsp;
   rrrh_pkg::rsp_type              out_rsp;
   logic                           stage_valid;
   logic                           advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= rrrh_pkg::TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         ticks_ff <= csr_ticks_per_timeout;
      end
   end

   assign in_req.opcode      = req_opcode;
   assign in_req.packet_id   = req_packet_id;
   assign in_req.link_opened = req_link_opened;

   // move a request on when the result register is free or draining
   assign advance = stage_valid && (!rsp_valid || rsp_ready);

   rrrh_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_req   (in_req),
      .advance  (advance),
      .valid    (stage_valid),
      .req      (stage_req)
   );

   rrrh_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .req               (stage_req),
      .ticks_per_timeout (ticks_ff),
      .rsp               (core_rsp)
   );

   rrrh_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rsp_in    (core_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .rsp       (out_rsp)
   );

   assign rsp_send_kind   = out_rsp.send_kind;
   assign rsp_send_id     = out_rsp.send_id;
   assign rsp_ack_pending = out_rsp.ack_pending;

endmodule
